FILE: design/ihx_pkg.sv
// ----------------------------------------------------------------------------
// ihx_pkg: shared types and constants of the Intel HEX record encoder
// Holds the queue entry layout, record kinds, record codes, ASCII codes and
// the nibble-to-hex-character function.
// ----------------------------------------------------------------------------
`default_nettype none

package ihx_pkg;

  // Record buffer geometry.
  localparam int BUF_DEPTH = 16;
  localparam int BUF_IDX_W = 4;
  localparam int CNT_W     = 5;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // Record type codes and fixed lengths.
  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;
  localparam logic [7:0] TYPE_ELA  = 8'h04;
  localparam logic [7:0] TYPE_SLA  = 8'h05;
  localparam logic [7:0] LEN_ELA   = 8'h02;
  localparam logic [7:0] LEN_SLA   = 8'h04;

  // ASCII codes.
  localparam logic [6:0] CHAR_COLON = 7'h3A;
  localparam logic [6:0] CHAR_CR    = 7'h0D;
  localparam logic [6:0] CHAR_LF    = 7'h0A;
  localparam logic [6:0] CHAR_NONE  = 7'h00;

  // Character counts of one result.
  localparam logic [1:0] COUNT_ONE = 2'd1;
  localparam logic [1:0] COUNT_TWO = 2'd2;

  // One classified input byte.
  typedef struct packed {
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] fill;      // buffer count including this byte
    logic             flush;     // this byte closes a data record
    logic             last;      // final byte of the image
  } ihx_job_t;

  // Kinds of record that the back emits.
  typedef enum logic [1:0] {
    REC_ELA   = 2'd0,
    REC_DATA  = 2'd1,
    REC_START = 2'd2,
    REC_END   = 2'd3
  } ihx_rec_t;

  // Upper-case hex character of one nibble.
  function automatic logic [6:0] hex_char(input logic [3:0] v);
    logic [6:0] w;
    w = {3'b000, v};
    if (v < 4'd10) begin
      hex_char = 7'h30 + w;
    end else begin
      hex_char = 7'h37 + w;
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/intel_hex_record_encoder.sv
// ----------------------------------------------------------------------------
// intel_hex_record_encoder: image bytes in, Intel HEX (I32HEX) text out
// Top level: start address register, input front, queue and record
// sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Image bytes arrive one per beat on the in_ stream; in_tlast marks the
// final byte of an image. Results leave on the out_ stream, one or two ASCII
// characters per beat; out_tlast marks the last beat caused by one byte.
// The start address is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, as the block does not enforce this. A byte that
// does not close a record is popped by the idle sequencer and gives no beat.
// A byte that closes a record passes through the queue to the sequencer,
// which starts its records once idle and gives one beat per cycle while the
// receiver takes them: a data record of n bytes is n + 7 beats, an extended
// address record 9, the start address record 11 and the end record 7.
// The front keeps accepting bytes into a four-entry queue while records are
// being written out, so input stalls only when that queue is full.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits. Reset clears the fill count, the address tracking, the
// queue and the start address; after the final byte of an image the
// address tracking returns to its reset state for the next image.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,  // image_start_address
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // data_byte[7:0]
  input  wire logic        in_tlast,     // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // first_char[6:0], second_char[13:7],
                                         // char_count[15:14]
  output logic             out_tlast     // run_end
);

  logic [31:0]        start_addr_r;
  logic               q_full;
  logic               q_push;
  logic               q_valid;
  logic               q_pop;
  ihx_pkg::ihx_job_t  push_job;
  ihx_pkg::ihx_job_t  pop_job;

  // Start address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= '0;
    end else if (cfg_wr_en) begin
      start_addr_r <= cfg_wr_data;
    end
  end

  ihx_front #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  ihx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (pop_job)
  );

  ihx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_addr (start_addr_r),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // A beat carries one or two characters.
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:14] == ihx_pkg::COUNT_ONE ||
                    out_tdata[15:14] == ihx_pkg::COUNT_TWO))
    else $error("char_count out of range");

  // A single-character beat is always the record mark.
  a_colon: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[15:14] == ihx_pkg::COUNT_ONE) |->
      (out_tdata[6:0] == ihx_pkg::CHAR_COLON && out_tdata[13:7] == ihx_pkg::CHAR_NONE))
    else $error("single-character beat is not a colon");

  // The last beat of a run always closes a record with CR LF.
  a_run_end_crlf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tdata[6:0] == ihx_pkg::CHAR_CR && out_tdata[13:7] == ihx_pkg::CHAR_LF))
    else $error("run end not on CR LF");

  // Nothing is offered in the first cycle after reset is released.
  a_reset_quiet: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

FILE: design/ihx_front.sv
// ----------------------------------------------------------------------------
// ihx_front: input side of the Intel HEX record encoder
// Accepts image bytes, keeps the record fill count and marks the bytes that
// close a data record.
// ----------------------------------------------------------------------------
`default_nettype none

module ihx_front #(
  parameter int RECORD_BYTES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,   // data_byte[7:0]
  input  wire logic            in_tlast,   // is_last
  input  wire logic            q_full,
  output logic                 q_push,
  output ihx_pkg::ihx_job_t    q_job
);

  localparam logic [ihx_pkg::CNT_W-1:0] LIMIT = ihx_pkg::CNT_W'(RECORD_BYTES);

  logic [ihx_pkg::CNT_W-1:0] fill_r;
  logic [ihx_pkg::CNT_W-1:0] fill_nxt;
  logic [ihx_pkg::CNT_W-1:0] count;
  logic                      flush;

  // Classify the byte: does it close a record?
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign count     = fill_r + ihx_pkg::CNT_W'(1);
  assign flush     = (count >= LIMIT) || in_tlast;

  assign q_job.data_byte = in_tdata;
  assign q_job.fill      = count;
  assign q_job.flush     = flush;
  assign q_job.last      = in_tlast;

  // Fill count restarts after each record.
  always_comb begin
    fill_nxt = fill_r;
    if (q_push) begin
      fill_nxt = flush ? '0 : count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/ihx_fifo.sv
// ----------------------------------------------------------------------------
// ihx_fifo: queue of classified bytes
// A short first-in first-out queue that lets the front and the back stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none

module ihx_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ihx_pkg::ihx_job_t push_job,
  output logic                   full,
  input  wire logic              pop,
  output logic                   pop_valid,
  output ihx_pkg::ihx_job_t      pop_job
);

  ihx_pkg::ihx_job_t                 mem_r [ihx_pkg::QUEUE_DEPTH];
  logic [ihx_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r;
  logic [ihx_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r;
  logic [ihx_pkg::QUEUE_CNT_W-1:0]   count_r;
  logic [ihx_pkg::QUEUE_CNT_W-1:0]   count_nxt;

  assign full      = (count_r == ihx_pkg::QUEUE_CNT_W'(ihx_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + ihx_pkg::QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - ihx_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ihx_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ihx_pkg::QUEUE_PTR_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: design/ihx_back.sv
// ----------------------------------------------------------------------------
// ihx_back: record sequencer of the Intel HEX record encoder
// Collects bytes into the record buffer and, when a record closes, emits the
// extended address, data, start address and end records as ASCII results.
// ----------------------------------------------------------------------------
`default_nettype none

module ihx_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       start_addr,
  input  wire logic              q_valid,
  input  wire ihx_pkg::ihx_job_t q_job,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,  // first_char[6:0], second_char[13:7],
                                             // char_count[15:14]
  output logic                   out_tlast   // run_end
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COLON = 5'b00010,
    S_BYTE  = 5'b00100,
    S_CSUM  = 5'b01000,
    S_CRLF  = 5'b10000
  } state_t;

  localparam int CW = ihx_pkg::CNT_W;

  // Sequencer state.
  state_t             state_r, state_nxt;
  ihx_pkg::ihx_rec_t  kind_r, kind_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic               last_r, last_nxt;
  logic [31:0]        addr_r, addr_nxt;
  logic [7:0]         csum_r, csum_nxt;

  // Image state.
  logic [31:0]        emitted_r, emitted_nxt;
  logic [15:0]        upper_r, upper_nxt;
  logic               known_r, known_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [6:0]         out_first_r, out_first_nxt;
  logic [6:0]         out_second_r, out_second_nxt;
  logic [1:0]         out_cnt_r, out_cnt_nxt;
  logic               out_last_r, out_last_nxt;

  // Record buffer.
  logic [7:0]         buf_r [ihx_pkg::BUF_DEPTH];

  logic               adv;
  logic [31:0]        job_addr;
  logic               need_ela;
  logic [CW-1:0]      data_pos;
  logic [7:0]         byte_val;
  logic [CW-1:0]      last_idx;

  assign q_pop    = q_valid && (state_r == S_IDLE);
  assign adv      = !out_valid_r || out_tready;
  assign job_addr = start_addr + emitted_r;
  assign need_ela = !known_r || (job_addr[31:16] != upper_r);
  assign data_pos = idx_r - CW'(4);

  // Byte of the current record at the current position.
  always_comb begin
    byte_val = 8'h00;
    unique case (kind_r)
      ihx_pkg::REC_ELA: begin
        unique case (idx_r)
          CW'(0):  byte_val = ihx_pkg::LEN_ELA;
          CW'(3):  byte_val = ihx_pkg::TYPE_ELA;
          CW'(4):  byte_val = addr_r[31:24];
          CW'(5):  byte_val = addr_r[23:16];
          default: byte_val = 8'h00;
        endcase
      end
      ihx_pkg::REC_DATA: begin
        unique case (idx_r)
          CW'(0):  byte_val = {3'b000, n_r};
          CW'(1):  byte_val = addr_r[15:8];
          CW'(2):  byte_val = addr_r[7:0];
          CW'(3):  byte_val = ihx_pkg::TYPE_DATA;
          default: byte_val = buf_r[data_pos[ihx_pkg::BUF_IDX_W-1:0]];
        endcase
      end
      ihx_pkg::REC_START: begin
        unique case (idx_r)
          CW'(0):  byte_val = ihx_pkg::LEN_SLA;
          CW'(3):  byte_val = ihx_pkg::TYPE_SLA;
          CW'(4):  byte_val = start_addr[31:24];
          CW'(5):  byte_val = start_addr[23:16];
          CW'(6):  byte_val = start_addr[15:8];
          CW'(7):  byte_val = start_addr[7:0];
          default: byte_val = 8'h00;
        endcase
      end
      ihx_pkg::REC_END: begin
        byte_val = (idx_r == CW'(3)) ? ihx_pkg::TYPE_EOF : 8'h00;
      end
      default: byte_val = 8'h00;
    endcase
  end

  // Position of the final byte before the checksum.
  always_comb begin
    unique case (kind_r)
      ihx_pkg::REC_ELA:   last_idx = CW'(5);
      ihx_pkg::REC_DATA:  last_idx = n_r + CW'(3);
      ihx_pkg::REC_START: last_idx = CW'(7);
      ihx_pkg::REC_END:   last_idx = CW'(3);
      default:            last_idx = CW'(3);
    endcase
  end

  // Sequencer: one result per cycle while the output register has room.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    last_nxt       = last_r;
    addr_nxt       = addr_r;
    csum_nxt       = csum_r;
    emitted_nxt    = emitted_r;
    upper_nxt      = upper_r;
    known_nxt      = known_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_pop && q_job.flush) begin
          n_nxt       = q_job.fill;
          last_nxt    = q_job.last;
          addr_nxt    = job_addr;
          kind_nxt    = need_ela ? ihx_pkg::REC_ELA : ihx_pkg::REC_DATA;
          state_nxt   = S_COLON;
          upper_nxt   = job_addr[31:16];
          known_nxt   = 1'b1;
          emitted_nxt = emitted_r + {27'd0, q_job.fill};
          // The image ends here: the next one starts from reset state.
          if (q_job.last) begin
            upper_nxt   = '0;
            known_nxt   = 1'b0;
            emitted_nxt = '0;
          end
        end
      end
      S_COLON: begin
        if (adv) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = ihx_pkg::CHAR_COLON;
          out_second_nxt = ihx_pkg::CHAR_NONE;
          out_cnt_nxt    = ihx_pkg::COUNT_ONE;
          out_last_nxt   = 1'b0;
          csum_nxt       = 8'h00;
          idx_nxt        = '0;
          state_nxt      = S_BYTE;
        end
      end
      S_BYTE: begin
        if (adv) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = ihx_pkg::hex_char(byte_val[7:4]);
          out_second_nxt = ihx_pkg::hex_char(byte_val[3:0]);
          out_cnt_nxt    = ihx_pkg::COUNT_TWO;
          out_last_nxt   = 1'b0;
          csum_nxt       = csum_r - byte_val;
          idx_nxt        = idx_r + CW'(1);
          if (idx_r == last_idx) begin
            state_nxt = S_CSUM;
          end
        end
      end
      S_CSUM: begin
        if (adv) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = ihx_pkg::hex_char(csum_r[7:4]);
          out_second_nxt = ihx_pkg::hex_char(csum_r[3:0]);
          out_cnt_nxt    = ihx_pkg::COUNT_TWO;
          out_last_nxt   = 1'b0;
          state_nxt      = S_CRLF;
        end
      end
      S_CRLF: begin
        if (adv) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = ihx_pkg::CHAR_CR;
          out_second_nxt = ihx_pkg::CHAR_LF;
          out_cnt_nxt    = ihx_pkg::COUNT_TWO;
          out_last_nxt   = 1'b0;
          state_nxt      = S_COLON;
          // Pick the next record, or finish the run.
          unique case (kind_r)
            ihx_pkg::REC_ELA: begin
              kind_nxt = ihx_pkg::REC_DATA;
            end
            ihx_pkg::REC_DATA: begin
              if (last_r) begin
                kind_nxt = ihx_pkg::REC_START;
              end else begin
                state_nxt    = S_IDLE;
                out_last_nxt = 1'b1;
              end
            end
            ihx_pkg::REC_START: begin
              kind_nxt = ihx_pkg::REC_END;
            end
            ihx_pkg::REC_END: begin
              state_nxt    = S_IDLE;
              out_last_nxt = 1'b1;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and image state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emitted_r   <= '0;
      upper_r     <= '0;
      known_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emitted_r   <= emitted_nxt;
      upper_r     <= upper_nxt;
      known_r     <= known_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    last_r       <= last_nxt;
    addr_r       <= addr_nxt;
    csum_r       <= csum_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Record buffer write: each byte lands at its place in the record.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      buf_r[q_job.fill[ihx_pkg::BUF_IDX_W-1:0] - ihx_pkg::BUF_IDX_W'(1)] <= q_job.data_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_second_r, out_first_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: dv/intel_hex_record_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_tb: self-checking bench of the Intel HEX encoder
// Streams images into the block under random start addresses. A built-in
// encoder turns each accepted byte into the text beats it must produce. Every
// output beat is compared against that text. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder_tb;

  localparam int          RECORD_LEN   = 16;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          RANDOM_BYTES = 330;
  localparam int          STEADY_BYTES = 60;
  localparam logic [7:0]  LEN_EOF      = 8'h00;

  // One output beat: up to two ASCII characters.
  typedef struct packed {
    logic [6:0] first_char;
    logic [6:0] second_char;
    logic [1:0] char_count;
    logic       run_end;
  } text_beat_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  // Encoder state kept alongside the block.
  logic [31:0] start_addr  = 32'h0;
  logic [7:0]  rec_bytes [RECORD_LEN];
  int unsigned rec_fill    = 0;
  logic [31:0] emitted     = 32'h0;
  logic [15:0] upper_seen  = 16'h0;
  bit          upper_valid = 1'b0;
  logic [7:0]  csum        = 8'h0;
  text_beat_t  held_beat;
  bit          held_valid  = 1'b0;
  text_beat_t  text_beats [$];

  bit          gaps_on      = 1'b1;
  int unsigned stall_left   = 0;
  int unsigned mismatches   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned images_sent  = 0;
  int unsigned addr_writes  = 0;
  int unsigned beats_seen   = 0;
  int unsigned cycle_count  = 0;

  intel_hex_record_encoder #(
    .RECORD_BYTES(RECORD_LEN)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // ASCII hex digit of one nibble, upper case.
  function automatic logic [6:0] nibble_ascii(input logic [3:0] v);
    if (v < 4'd10) begin
      return 7'h30 + {3'b000, v};
    end
    return 7'h41 + {3'b000, v} - 7'd10;
  endfunction

  // The previous beat is released only when a later one exists, so the
  // final beat of a byte can still get its run_end flag.
  task automatic put_beat(input logic [6:0] c1, input logic [6:0] c2,
                          input logic [1:0] cnt);
    if (held_valid) begin
      text_beats.push_back(held_beat);
    end
    held_beat  = '{first_char: c1, second_char: c2, char_count: cnt, run_end: 1'b0};
    held_valid = 1'b1;
  endtask

  task automatic open_record();
    csum = 8'h00;
    put_beat(ihx_pkg::CHAR_COLON, ihx_pkg::CHAR_NONE, ihx_pkg::COUNT_ONE);
  endtask

  task automatic record_byte(input logic [7:0] b);
    csum = csum - b;
    put_beat(nibble_ascii(b[7:4]), nibble_ascii(b[3:0]), ihx_pkg::COUNT_TWO);
  endtask

  task automatic close_record();
    put_beat(nibble_ascii(csum[7:4]), nibble_ascii(csum[3:0]), ihx_pkg::COUNT_TWO);
    put_beat(ihx_pkg::CHAR_CR, ihx_pkg::CHAR_LF, ihx_pkg::COUNT_TWO);
  endtask

  // Text that one accepted image byte must produce.
  task automatic encode_byte(input logic [7:0] value, input logic final_byte);
    logic [31:0] addr;
    logic [15:0] upper;
    rec_bytes[rec_fill] = value;
    rec_fill = rec_fill + 1;
    if (rec_fill >= RECORD_LEN || final_byte) begin
      addr  = start_addr + emitted;
      upper = addr[31:16];
      // Extended linear address record when the upper half changes.
      if (!upper_valid || upper != upper_seen) begin
        open_record();
        record_byte(ihx_pkg::LEN_ELA);
        record_byte(8'h00);
        record_byte(8'h00);
        record_byte(ihx_pkg::TYPE_ELA);
        record_byte(upper[15:8]);
        record_byte(upper[7:0]);
        close_record();
        upper_seen  = upper;
        upper_valid = 1'b1;
      end
      open_record();
      record_byte(8'(rec_fill));
      record_byte(addr[15:8]);
      record_byte(addr[7:0]);
      record_byte(ihx_pkg::TYPE_DATA);
      for (int i = 0; i < rec_fill; i++) begin
        record_byte(rec_bytes[i]);
      end
      close_record();
      emitted  = emitted + 32'(rec_fill);
      rec_fill = 0;
    end
    // Start address and end-of-file records close the image.
    if (final_byte) begin
      open_record();
      record_byte(ihx_pkg::LEN_SLA);
      record_byte(8'h00);
      record_byte(8'h00);
      record_byte(ihx_pkg::TYPE_SLA);
      record_byte(start_addr[31:24]);
      record_byte(start_addr[23:16]);
      record_byte(start_addr[15:8]);
      record_byte(start_addr[7:0]);
      close_record();
      open_record();
      record_byte(LEN_EOF);
      record_byte(8'h00);
      record_byte(8'h00);
      record_byte(ihx_pkg::TYPE_EOF);
      close_record();
      rec_fill    = 0;
      emitted     = 32'h0;
      upper_seen  = 16'h0;
      upper_valid = 1'b0;
      csum        = 8'h00;
    end
    if (held_valid) begin
      held_beat.run_end = 1'b1;
      text_beats.push_back(held_beat);
      held_valid = 1'b0;
    end
  endtask

  // Sends one image byte and waits for its beat to be taken.
  task automatic send_byte(input logic [7:0] value, input logic final_byte);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= final_byte;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encode_byte(value, final_byte);
    bytes_sent++;
    if (final_byte) begin
      images_sent++;
    end
  endtask

  // Waits until all expected text is out and the block has settled.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (text_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    start_addr = value;
    addr_writes++;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_address();
    case ($urandom_range(0, 4))
      0: return $urandom;
      // Just below a 64K boundary, so records cross into the next segment.
      1: return {16'($urandom), 16'h0000} - 32'($urandom_range(1, 40));
      2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
      3: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic int unsigned pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 20);
      6: return RECORD_LEN * $urandom_range(1, 3);
      7: return RECORD_LEN * $urandom_range(1, 2) + 1;
      8: return $urandom_range(21, 60);
      default: return $urandom_range(61, 120);
    endcase
  endfunction

  // One image of random bytes; the start address may be rewritten at a
  // record boundary once the block is idle.
  task automatic run_image(input int unsigned length, input logic [31:0] base,
                           input bit allow_rewrite);
    write_start(base);
    for (int i = 0; i < length; i++) begin
      send_byte(8'($urandom), i == length - 1);
      if (allow_rewrite && i != length - 1 && rec_fill == 0 &&
          $urandom_range(0, 3) == 0) begin
        wait_drain();
        write_start(pick_address());
      end
    end
    wait_drain();
  endtask

  // Single-byte image at address zero.
  task automatic test_single_byte_image();
    write_start(32'h0000_0000);
    send_byte(8'h00, 1'b1);
    wait_drain();
  endtask

  // Full record at the top of memory, then the last byte wraps to address 8.
  task automatic test_wrap_after_full_record();
    write_start(32'hFFFF_FFF8);
    for (int i = 0; i <= RECORD_LEN; i++) begin
      send_byte(8'(i * 17), i == RECORD_LEN);
    end
    wait_drain();
  endtask

  // A record that runs past the end of the address space stays whole.
  task automatic test_record_across_top();
    write_start(32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_images();
    int unsigned goal;
    int unsigned length;
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      length = pick_length();
      // The final image is cut so the byte budget is met closely.
      if (length > goal - bytes_sent) begin
        length = goal - bytes_sent;
      end
      run_image(length, pick_address(), 1'b1);
    end
  endtask

  // Closing stretch with both sides running flat out.
  task automatic test_steady_stream();
    int unsigned goal;
    int unsigned length;
    gaps_on = 1'b0;
    goal = bytes_sent + STEADY_BYTES;
    while (bytes_sent < goal) begin
      length = $urandom_range(1, 40);
      if (length > goal - bytes_sent) begin
        length = goal - bytes_sent;
      end
      run_image(length, pick_address(), 1'b0);
    end
  endtask

  // Receiver stalls at random while gaps are enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Each output beat is compared with the oldest expected one.
  always @(posedge clk) begin : check_beats
    text_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (text_beats.size() == 0) begin
        $error("unexpected beat: tdata %h, tlast %b", out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = text_beats.pop_front();
        check_field("first_char", want.first_char, out_tdata[6:0]);
        check_field("second_char", want.second_char, out_tdata[13:7]);
        check_field("char_count", want.char_count, out_tdata[15:14]);
        check_field("run_end", want.run_end, out_tlast);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_byte_image();
    test_wrap_after_full_record();
    test_record_across_top();
    test_random_images();
    test_steady_stream();
    $display("Encoded %0d bytes in %0d images with %0d start address writes.",
             bytes_sent, images_sent, addr_writes);
    $display("Checked %0d text beats, %0d mismatches.", beats_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ihx_pkg.sv
design/ihx_front.sv
design/ihx_fifo.sv
design/ihx_back.sv
design/intel_hex_record_encoder.sv
dv/intel_hex_record_encoder_tb.sv
